// ===== rtl/cht_pkg.sv =====
package cht_pkg;

  localparam int NUM_BUCKETS  = 64;
  localparam int BUCKET_DEPTH = 4;
  localparam int KEY_BYTES    = 8;
  localparam int REF_BITS     = 16;

  localparam int KEY_W      = 8 * KEY_BYTES;
  localparam int LEN_W      = $clog2(KEY_BYTES + 1);
  localparam int BUCKET_W   = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int SUM_W      = BUCKET_W + 3;
  localparam int CNT_W      = $clog2(BUCKET_DEPTH + 1);
  localparam int IDX_W      = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
  localparam int SLOT_COUNT = NUM_BUCKETS * BUCKET_DEPTH;
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int ENTRY_W    = KEY_W + LEN_W + REF_BITS;

  typedef logic [BUCKET_W-1:0] bucket_t;
  typedef bucket_t byte_mod_t [256];

  // residue of every byte value modulo the bucket count
  function automatic byte_mod_t build_byte_mod();
    byte_mod_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = BUCKET_W'(i % NUM_BUCKETS);
    end
    return t;
  endfunction

  localparam byte_mod_t BYTE_MOD = build_byte_mod();

  typedef enum logic [1:0] {
    STATUS_INSERTED  = 2'd0,
    STATUS_FOUND     = 2'd1,
    STATUS_NOT_FOUND = 2'd2,
    STATUS_FULL      = 2'd3
  } status_t;

  typedef enum logic {
    MODE_INSERT = 1'b0,
    MODE_LOOKUP = 1'b1
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_MOD,
    ST_CNT,
    ST_DEC,
    ST_CMP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [LEN_W-1:0]    len;
    logic [REF_BITS-1:0] item_ref;
  } entry_t;

endpackage

// ===== rtl/cht_ram.sv =====
module cht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/cht_hash.sv =====
module cht_hash import cht_pkg::*; (
  input  logic             clk,
  input  logic             load,
  input  logic [KEY_W-1:0] key,
  output bucket_t          bucket
);

  localparam logic [SUM_W-1:0] N1 = SUM_W'(NUM_BUCKETS);
  localparam logic [SUM_W-1:0] N2 = SUM_W'(2 * NUM_BUCKETS);
  localparam logic [SUM_W-1:0] N4 = SUM_W'(4 * NUM_BUCKETS);

  logic [SUM_W-1:0] sum, sum_next;
  logic [SUM_W-1:0] r1, r2, r3;

  // per-byte residues summed, stays below eight times the bucket count
  always_comb begin
    sum_next = '0;
    for (int i = 0; i < KEY_BYTES; i++) begin
      sum_next = sum_next + SUM_W'(BYTE_MOD[key[i*8 +: 8]]);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sum <= sum_next;
    end
  end

  // three restoring steps bring the sum below the bucket count
  always_comb begin
    r1 = (sum >= N4) ? sum - N4 : sum;
    r2 = (r1 >= N2) ? r1 - N2 : r1;
    r3 = (r2 >= N1) ? r2 - N1 : r2;
  end

  assign bucket = r3[BUCKET_W-1:0];

endmodule

// ===== rtl/chained_hash_table_core.sv =====
// chained hash table: insert or look up keys of up to eight bytes
// input channel in_valid/in_ready carries mode, key, key_length, item_ref;
// output channel out_valid/out_ready carries status and found_ref, one
// result item per input item, in order
// the bucket is the sum of the key bytes modulo the bucket count; each
// bucket holds up to four entries in an entry memory, with a count memory
// holding the fill level of every bucket
// one item at a time: an item passes the sum, modulo, count and decode
// states and then waits in the done state for the output register; a
// lookup compares up to four entries between decode and done, stopping at
// the first match; one shared compare unit walks the bucket one entry
// per cycle from the single read port of the entry memory
// the result sits in an output register, so the next item is accepted
// while it waits; if the receiver still holds an older result when a new
// one is ready, the sequencer waits in its final state
// reset clears the state machine, the output valid and the per-bucket
// valid bits, so every bucket starts empty with no clearing pass
module chained_hash_table_core import cht_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        mode,
  input  logic [63:0] key,
  input  logic [3:0]  key_length,
  input  logic [15:0] item_ref,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [15:0] found_ref
);

  state_t state, state_next;

  logic                   op_mode;
  logic [KEY_W-1:0]       op_key;
  logic [LEN_W-1:0]       op_len;
  logic [REF_BITS-1:0]    op_ref;
  bucket_t                bucket;
  logic [SLOT_W-1:0]      slot_base;
  logic [CNT_W-1:0]       count;
  logic [IDX_W-1:0]       cmp_idx;
  logic [IDX_W-1:0]       rd_idx;
  status_t                res_status;
  logic [15:0]            res_ref;
  logic [NUM_BUCKETS-1:0] bucket_valid;

  logic                accept;
  logic [LEN_W-1:0]    len_sat;
  logic [KEY_W-1:0]    key_m;
  logic [REF_BITS-1:0] ref_in;
  bucket_t             hash_bucket;
  logic                hash_load;
  logic [CNT_W-1:0]    cnt_rdata;
  logic [CNT_W-1:0]    cnt_cur;
  logic                cnt_we;
  logic                ent_we;
  logic [SLOT_W-1:0]   ent_waddr;
  logic [SLOT_W-1:0]   ent_raddr;
  entry_t              ent_wdata;
  entry_t              ent_rdata;
  logic                full;
  logic                match;
  logic                last;
  logic                out_free;
  logic [IDX_W-1:0]    rd_idx_inc;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // length saturation and masking of unused key bytes
  always_comb begin
    if (key_length > 4'(KEY_BYTES)) begin
      len_sat = LEN_W'(KEY_BYTES);
    end else begin
      len_sat = LEN_W'(key_length);
    end
    for (int i = 0; i < KEY_BYTES; i++) begin
      key_m[i*8 +: 8] = (i < int'(len_sat)) ? key[i*8 +: 8] : 8'h00;
    end
  end

  assign ref_in = REF_BITS'(item_ref);

  cht_hash u_hash (
    .clk    (clk),
    .load   (hash_load),
    .key    (op_key),
    .bucket (hash_bucket)
  );

  cht_ram #(
    .WIDTH (CNT_W),
    .DEPTH (NUM_BUCKETS)
  ) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (bucket),
    .wdata (cnt_cur + CNT_W'(1)),
    .raddr (bucket),
    .rdata (cnt_rdata)
  );

  cht_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOT_COUNT)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  assign cnt_cur    = bucket_valid[bucket] ? cnt_rdata : '0;
  assign full       = (cnt_cur >= CNT_W'(BUCKET_DEPTH));
  assign ent_waddr  = slot_base + SLOT_W'(cnt_cur);
  assign ent_raddr  = slot_base + SLOT_W'(rd_idx);
  assign ent_wdata  = '{key: op_key, len: op_len, item_ref: op_ref};
  assign match      = (ent_rdata.len == op_len) && (ent_rdata.key == op_key);
  assign last       = ((CNT_W'(cmp_idx) + CNT_W'(1)) == count);
  assign rd_idx_inc = (rd_idx == IDX_W'(BUCKET_DEPTH - 1)) ? '0 : rd_idx + IDX_W'(1);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_SUM;
        end
      end
      ST_SUM: state_next = ST_MOD;
      ST_MOD: state_next = ST_CNT;
      ST_CNT: state_next = ST_DEC;
      ST_DEC: begin
        if (op_mode == MODE_LOOKUP && cnt_cur != '0) begin
          state_next = ST_CMP;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_CMP: begin
        if (match || last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    hash_load = 1'b0;
    cnt_we    = 1'b0;
    ent_we    = 1'b0;
    case (state)
      ST_SUM: hash_load = 1'b1;
      ST_DEC: begin
        cnt_we = (op_mode == MODE_INSERT) && !full;
        ent_we = (op_mode == MODE_INSERT) && !full;
      end
      default: begin
        hash_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      out_valid    <= 1'b0;
      bucket_valid <= '0;
    end else begin
      state <= state_next;
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cnt_we) begin
        bucket_valid[bucket] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          op_mode <= mode;
          op_key  <= key_m;
          op_len  <= len_sat;
          op_ref  <= ref_in;
          rd_idx  <= '0;
        end
      end
      ST_MOD: bucket <= hash_bucket;
      ST_CNT: slot_base <= SLOT_W'(bucket) * SLOT_W'(BUCKET_DEPTH);
      ST_DEC: begin
        count   <= cnt_cur;
        cmp_idx <= '0;
        rd_idx  <= rd_idx_inc;
        res_ref <= '0;
        if (op_mode == MODE_INSERT) begin
          res_status <= full ? STATUS_FULL : STATUS_INSERTED;
        end else begin
          res_status <= STATUS_NOT_FOUND;
        end
      end
      ST_CMP: begin
        if (match) begin
          res_status <= STATUS_FOUND;
          res_ref    <= 16'(ent_rdata.item_ref);
        end else if (last) begin
          res_status <= STATUS_NOT_FOUND;
          res_ref    <= '0;
        end else begin
          cmp_idx <= cmp_idx + IDX_W'(1);
          rd_idx  <= rd_idx_inc;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          status    <= res_status;
          found_ref <= res_ref;
        end
      end
      default: begin
        rd_idx <= rd_idx;
      end
    endcase
  end

endmodule

// ===== rtl/cht_checker.sv =====
module cht_checker import cht_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [15:0] found_ref
);

  // a held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(found_ref))
    else $error("result changed while stalled");

  // only a found result carries a reference
  a_ref_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STATUS_FOUND |-> found_ref == 16'd0)
    else $error("nonzero reference without a match");

  // busy right after an item is taken
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted an item while busy");

  // with no result shown, taking an item does not make one appear right away
  a_no_early: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result appeared too early");

  // nothing is shown right after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind chained_hash_table_core cht_checker u_cht_checker (.*);

// ===== sim/chained_hash_table_core_tb.sv =====
`timescale 1ns / 100ps

module chained_hash_table_core_tb import cht_pkg::*; ();

  typedef struct {
    status_t     status;
    logic [15:0] found_ref;
  } table_reply_t;

  typedef struct {
    logic [63:0] key;
    logic [3:0]  len;
  } stored_key_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        mode = MODE_INSERT;
  logic [63:0] key = '0;
  logic [3:0]  key_length = 4'd1;
  logic [15:0] item_ref = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [15:0] found_ref;

  bit          steady_traffic = 1'b0;
  int          error_count = 0;
  int          item_count = 0;
  int          insert_count = 0;
  int          found_count = 0;
  int          miss_count = 0;
  int          full_count = 0;

  // shadow of the table
  int unsigned bucket_fill [NUM_BUCKETS];
  logic [63:0] slot_key [SLOT_COUNT];
  logic [3:0]  slot_len [SLOT_COUNT];
  logic [15:0] slot_ref [SLOT_COUNT];

  table_reply_t replies_due [$];
  stored_key_t  inserted_keys [$];

  chained_hash_table_core u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .key        (key),
    .key_length (key_length),
    .item_ref   (item_ref),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .found_ref  (found_ref)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("timeout: %0d results still due", replies_due.size());
    $display("FAILURE");
    $finish;
  end

  initial begin
    for (int i = 0; i < NUM_BUCKETS; i++) begin
      bucket_fill[i] = 0;
    end
  end

  function automatic table_reply_t hash_table_access(input logic op, input logic [63:0] k,
                                                     input logic [3:0] len_in,
                                                     input logic [15:0] ref_in);
    table_reply_t res;
    int unsigned  len, sum, b, n, s, i;
    logic [63:0]  kk;
    len = (len_in > KEY_BYTES) ? KEY_BYTES : len_in;
    kk  = '0;
    sum = 0;
    for (i = 0; i < len; i++) begin
      kk[i*8 +: 8] = k[i*8 +: 8];
      sum += k[i*8 +: 8];
    end
    b = sum % NUM_BUCKETS;
    n = bucket_fill[b];
    res.status    = STATUS_NOT_FOUND;
    res.found_ref = '0;
    if (op == MODE_INSERT) begin
      if (n >= BUCKET_DEPTH) begin
        res.status = STATUS_FULL;
      end else begin
        s = b * BUCKET_DEPTH + n;
        slot_key[s]    = kk;
        slot_len[s]    = 4'(len);
        slot_ref[s]    = ref_in;
        bucket_fill[b] = n + 1;
        res.status     = STATUS_INSERTED;
      end
    end else begin
      for (i = 0; i < n; i++) begin
        s = b * BUCKET_DEPTH + i;
        if (res.status == STATUS_NOT_FOUND && slot_len[s] == len && slot_key[s] == kk) begin
          res.status    = STATUS_FOUND;
          res.found_ref = slot_ref[s];
        end
      end
    end
    return res;
  endfunction

  // accepted items feed the shadow table, returned items are checked
  always @(posedge clk) begin
    table_reply_t want;
    table_reply_t got;
    if (!rst && out_valid && out_ready) begin
      if (replies_due.size() == 0) begin
        error_count++;
        if (error_count <= 10) begin
          $display("unexpected result: status %0d found_ref %04h", status, found_ref);
        end
      end else begin
        want = replies_due.pop_front();
        if (status !== want.status || found_ref !== want.found_ref) begin
          error_count++;
          if (error_count <= 10) begin
            $display("mismatch: status exp %0d got %0d, found_ref exp %04h got %04h",
                     want.status, status, want.found_ref, found_ref);
          end
        end
      end
    end
    if (!rst && in_valid && in_ready) begin
      got = hash_table_access(mode, key, key_length, item_ref);
      item_count++;
      case (got.status)
        STATUS_INSERTED:  insert_count++;
        STATUS_FOUND:     found_count++;
        STATUS_NOT_FOUND: miss_count++;
        default:          full_count++;
      endcase
      replies_due.push_back(got);
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      out_ready <= steady_traffic || ($urandom_range(99) >= 15);
    end
  end

  task automatic send_item(input logic op, input logic [63:0] k, input logic [3:0] len,
                           input logic [15:0] r);
    if (!steady_traffic && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    mode       <= op;
    key        <= k;
    key_length <= len;
    item_ref   <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (replies_due.size() != 0);
    repeat (16) @(posedge clk);
  endtask

  // random key whose byte sum lands in bucket b
  function automatic logic [63:0] key_for_bucket(input int unsigned b, input int unsigned len);
    logic [63:0] k;
    int unsigned rest, base, i;
    k    = {$urandom, $urandom};
    rest = 0;
    for (i = 1; i < len; i++) begin
      rest += k[i*8 +: 8];
    end
    base    = (b + NUM_BUCKETS - (rest % NUM_BUCKETS)) % NUM_BUCKETS;
    k[7:0]  = 8'(base + NUM_BUCKETS * $urandom_range((255 - base) / NUM_BUCKETS));
    return k;
  endfunction

  function automatic logic [3:0] random_length();
    int r;
    r = $urandom_range(99);
    if (r < 4) return 4'd0;
    if (r < 10) return 4'($urandom_range(9, 15));
    return 4'($urandom_range(1, 8));
  endfunction

  task automatic test_special_keys();
    send_item(MODE_LOOKUP, 64'h0, 4'd1, 16'h0);
    send_item(MODE_INSERT, '1, 4'd8, 16'hffff);
    send_item(MODE_LOOKUP, '1, 4'd8, 16'h0);
    send_item(MODE_LOOKUP, '1, 4'd15, 16'h0);
    send_item(MODE_INSERT, 64'h0, 4'd0, 16'h1234);
    send_item(MODE_LOOKUP, 64'hdead_beef_cafe_f00d, 4'd0, 16'hffff);
    send_item(MODE_LOOKUP, 64'h0, 4'd1, 16'h0);
    send_item(MODE_INSERT, 64'ha5a5_5a5a_c3c3_3c00, 4'd1, 16'h0000);
    send_item(MODE_LOOKUP, 64'h1234_5678_9abc_de00, 4'd1, 16'h0);
    send_item(MODE_INSERT, 64'h8877_6655_4433_2211, 4'd9, 16'h5aa5);
    send_item(MODE_LOOKUP, 64'h8877_6655_4433_2211, 4'd8, 16'h0);
  endtask

  task automatic test_duplicates();
    send_item(MODE_INSERT, 64'h0102, 4'd2, 16'haaaa);
    send_item(MODE_INSERT, 64'h0102, 4'd2, 16'h5555);
    send_item(MODE_LOOKUP, 64'hffff_0102, 4'd2, 16'h0);
  endtask

  task automatic test_bucket_overflow();
    logic [63:0] keys [BUCKET_DEPTH];
    logic [63:0] k;
    for (int i = 0; i < BUCKET_DEPTH; i++) begin
      keys[i] = key_for_bucket(17, 4);
      send_item(MODE_INSERT, keys[i], 4'd4, 16'($urandom));
    end
    send_item(MODE_INSERT, key_for_bucket(17, 6), 4'd6, 16'h7e7e);
    for (int i = BUCKET_DEPTH - 1; i >= 0; i--) begin
      send_item(MODE_LOOKUP, keys[i], 4'd4, 16'h0);
    end
    k = keys[0];
    k[15:0] = {k[7:0], k[15:8]};
    send_item(MODE_LOOKUP, k, 4'd4, 16'h0);
  endtask

  task automatic test_random_traffic(input int count);
    int          n, sel, i, j, le;
    logic [63:0] k;
    logic [3:0]  len;
    logic [7:0]  t;
    stored_key_t e;
    for (n = 0; n < count; n++) begin
      sel = $urandom_range(99);
      if (sel < 30) begin
        len = random_length();
        if ($urandom_range(3) == 0 && len >= 1 && len <= 8) begin
          k = key_for_bucket($urandom_range(7) * 8, len);
        end else begin
          k = {$urandom, $urandom};
        end
        e.key = k;
        e.len = len;
        inserted_keys.push_back(e);
        send_item(MODE_INSERT, k, len, 16'($urandom));
      end else if (sel < 75 && inserted_keys.size() != 0) begin
        e   = inserted_keys[$urandom_range(inserted_keys.size() - 1)];
        k   = e.key;
        len = e.len;
        le  = (len > KEY_BYTES) ? KEY_BYTES : len;
        for (i = le; i < KEY_BYTES; i++) begin
          k[i*8 +: 8] = 8'($urandom);
        end
        sel = $urandom_range(99);
        if (sel < 12) begin
          len = 4'($urandom_range(15));
        end else if (sel < 27 && le >= 2) begin
          i = $urandom_range(le - 1);
          j = (i + 1 + $urandom_range(le - 2)) % le;
          t = k[i*8 +: 8];
          k[i*8 +: 8] = k[j*8 +: 8];
          k[j*8 +: 8] = t;
        end else if (sel < 37 && le >= 1) begin
          k[$urandom_range(le * 8 - 1)] ^= 1'b1;
        end else if (sel < 45 && le == KEY_BYTES) begin
          len = 4'($urandom_range(KEY_BYTES, 15));
        end
        send_item(MODE_LOOKUP, k, len, 16'($urandom));
      end else begin
        send_item(MODE_LOOKUP, {$urandom, $urandom}, random_length(), 16'($urandom));
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_special_keys();
    test_duplicates();
    test_bucket_overflow();
    wait_results_drained();
    test_random_traffic(500);
    wait_results_drained();
    steady_traffic = 1'b1;
    test_random_traffic(400);
    wait_results_drained();
    steady_traffic = 1'b0;
    test_random_traffic(325);
    wait_results_drained();
    if (replies_due.size() != 0) begin
      $display("%0d results never arrived", replies_due.size());
    end
    $display("run covered %0d items with random stalls on both channels", item_count);
    $display("inserted %0d, found %0d, not found %0d, bucket full %0d",
             insert_count, found_count, miss_count, full_count);
    if (error_count == 0 && replies_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
